### sv/u2l_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u2l_pkg;

   // raw bytes one item can flush ahead of, or instead of, an escape
   localparam int RAW_MAX     = 4;
   localparam int RAW_CNT_W   = $clog2(RAW_MAX + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int POINT_W     = 21;
   localparam int POS_W       = 4;

   localparam logic [7:0]         MARK_BYTE  = 8'h25;
   localparam logic [7:0]         ESC_SHORT_TAG = 8'h75;   // 'u'
   localparam logic [7:0]         ESC_LONG_TAG  = 8'h55;   // 'U'
   localparam logic [POINT_W-1:0] POINT_MAX  = 21'h10FFFF;
   localparam logic [POINT_W-1:0] SURR_LO    = 21'h00D800;
   localparam logic [POINT_W-1:0] SURR_HI    = 21'h00DFFF;
   localparam logic [POINT_W-1:0] MIN_TWO    = 21'h000080;
   localparam logic [POINT_W-1:0] MIN_THREE  = 21'h000800;
   localparam logic [POINT_W-1:0] MIN_FOUR   = 21'h010000;
   localparam logic [POINT_W-1:0] BMP_MAX    = 21'h00FFFF;
   localparam logic [POINT_W-1:0] LATIN1_MAX = 21'h0000FF;

   localparam logic [POS_W-1:0] ESC_SHORT_LEN = 4'd6;
   localparam logic [POS_W-1:0] ESC_LONG_LEN  = 4'd8;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_SHORT,
      ESC_LONG
   } esc_kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } rsp_type;

   // one item's worth of output, as the back end expands it
   typedef struct packed {
      logic [RAW_MAX-1:0][7:0] raw;
      logic [RAW_CNT_W-1:0]    raw_count;
      esc_kind_type            esc;
      logic [POINT_W-1:0]      point;
      logic                    eos;
   } job_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QPTR_W:0]   count;
   } q_status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      if (nib < 4'd10) begin
         hex_char = 8'h30 + wide;
      end else begin
         hex_char = 8'h37 + wide;
      end
   endfunction

endpackage

`default_nettype wire

### sv/u2l_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u2l_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire u2l_pkg::req_type req_data,
   input  wire logic             q_full,
   output logic                  job_valid,
   output u2l_pkg::job_type      job
);
   import u2l_pkg::*;

   logic [7:0]         lead_ff, lead_in;
   logic [2:0][7:0]    cont_ff, cont_in;
   logic [1:0]         need_ff, need_in;
   logic [1:0]         seen_ff, seen_in;
   logic [POINT_W-1:0] acc_ff, acc_in;

   logic               accept;
   logic [7:0]         b;
   logic               eos;
   logic               is_cont;
   logic [1:0]         seen_next;
   logic [POINT_W-1:0] acc_shift;
   logic [POINT_W-1:0] lo;
   logic [2:0][7:0]    cont_upd;
   logic               fresh;
   logic               put_pt;
   logic               put_raw;
   logic [POINT_W-1:0] pt;
   logic               invalid;

   assign accept = req_push & ~q_full;

   always_comb begin
      b         = req_data.in_byte;
      eos       = req_data.end_of_string;
      is_cont   = (b[7:6] == 2'b10);
      seen_next = seen_ff + 2'd1;
      acc_shift = {acc_ff[POINT_W-7:0], b[5:0]};
      cont_upd  = cont_ff;
      if (seen_ff != 2'd3) begin
         cont_upd[seen_ff] = b;
      end
      case (need_ff)
         2'd1:    lo = MIN_TWO;
         2'd2:    lo = MIN_THREE;
         default: lo = MIN_FOUR;
      endcase
      invalid = (acc_shift < lo) || (acc_shift > POINT_MAX)
              || ((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI));

      lead_in = lead_ff;
      cont_in = cont_ff;
      need_in = need_ff;
      seen_in = seen_ff;
      acc_in  = acc_ff;

      job           = '0;
      job.raw       = {cont_ff, lead_ff};
      job.raw_count = '0;
      job.esc       = ESC_NONE;
      job.eos       = eos;
      fresh         = 1'b1;
      put_pt        = 1'b0;
      put_raw       = 1'b0;
      pt            = {13'd0, b};

      if (need_ff != 2'd0) begin
         // close the open sequence unless it keeps growing below
         lead_in = '0;
         need_in = '0;
         seen_in = '0;
         acc_in  = '0;
         if (is_cont) begin
            fresh = 1'b0;
            if (seen_next >= need_ff) begin
               if (invalid) begin
                  job.raw       = {cont_upd, lead_ff};
                  job.raw_count = {1'b0, seen_next} + 3'd1;
               end else begin
                  put_pt = 1'b1;
                  pt     = acc_shift;
               end
            end else if (eos) begin
               job.raw       = {cont_upd, lead_ff};
               job.raw_count = {1'b0, seen_next} + 3'd1;
            end else begin
               lead_in = lead_ff;
               need_in = need_ff;
               cont_in = cont_upd;
               seen_in = seen_next;
               acc_in  = acc_shift;
            end
         end else begin
            job.raw_count = {1'b0, seen_ff} + 3'd1;
         end
      end

      if (fresh) begin
         if (!b[7]) begin
            put_pt = 1'b1;
         end else if ((b[7:5] == 3'b110) || (b[7:4] == 4'b1110)
                      || (b[7:3] == 5'b11110)) begin
            if (eos) begin
               put_raw = 1'b1;
            end else begin
               lead_in = b;
               seen_in = '0;
               if (b[7:5] == 3'b110) begin
                  need_in = 2'd1;
                  acc_in  = {16'd0, b[4:0]};
               end else if (b[7:4] == 4'b1110) begin
                  need_in = 2'd2;
                  acc_in  = {17'd0, b[3:0]};
               end else begin
                  need_in = 2'd3;
                  acc_in  = {18'd0, b[2:0]};
               end
            end
         end else begin
            put_raw = 1'b1;
         end
      end

      if (put_pt && ((pt == {13'd0, MARK_BYTE}) || (pt > LATIN1_MAX))) begin
         job.esc   = (pt <= BMP_MAX) ? ESC_SHORT : ESC_LONG;
         job.point = pt;
      end else if (put_pt || put_raw) begin
         job.raw[job.raw_count[1:0]] = put_pt ? pt[7:0] : b;
         job.raw_count               = job.raw_count + 3'd1;
      end

      job_valid = accept & ((job.raw_count != '0) || (job.esc != ESC_NONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
         need_ff <= '0;
         seen_ff <= '0;
         acc_ff  <= '0;
      end else if (accept) begin
         lead_ff <= lead_in;
         need_ff <= need_in;
         seen_ff <= seen_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cont_ff <= cont_in;
      end
   end

endmodule

`default_nettype wire

### sv/u2l_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u2l_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire u2l_pkg::job_type push_job,
   input  wire logic             pop,
   output u2l_pkg::job_type      head_job,
   output u2l_pkg::q_status_type status
);
   import u2l_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      status.count = count_ff;
      status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push & ~status.full;
      do_pop       = pop & ~status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
      head_job     = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### sv/u2l_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u2l_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire u2l_pkg::job_type head_job,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output u2l_pkg::rsp_type      rsp_data
);
   import u2l_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             load;
   logic             step;
   logic [POS_W-1:0] esc_len;
   logic [POS_W-1:0] total;
   logic [POS_W-1:0] raw_cnt;
   logic [POS_W-1:0] esc_pos;
   logic [POS_W-1:0] ndig;
   logic [2:0]       nib_idx;
   logic [23:0]      point_ext;
   logic [3:0]       nib;
   logic             last;
   logic [7:0]       cur_byte;

   always_comb begin
      case (head_job.esc)
         ESC_SHORT: begin
            esc_len = ESC_SHORT_LEN;
            ndig    = 4'd4;
         end
         ESC_LONG: begin
            esc_len = ESC_LONG_LEN;
            ndig    = 4'd6;
         end
         default: begin
            esc_len = '0;
            ndig    = '0;
         end
      endcase
      raw_cnt   = {1'b0, head_job.raw_count};
      total     = raw_cnt + esc_len;
      last      = (pos_ff == total - 4'd1);
      esc_pos   = pos_ff - raw_cnt;
      // digits run from the top nibble down; the first two escape bytes are the mark and tag
      nib_idx   = 3'(ndig + 4'd1 - esc_pos);
      point_ext = {3'd0, head_job.point};
      nib       = 4'(point_ext >> {nib_idx, 2'b00});

      if (pos_ff < raw_cnt) begin
         cur_byte = head_job.raw[pos_ff[1:0]];
      end else if (esc_pos == 4'd0) begin
         cur_byte = MARK_BYTE;
      end else if (esc_pos == 4'd1) begin
         cur_byte = (head_job.esc == ESC_SHORT) ? ESC_SHORT_TAG : ESC_LONG_TAG;
      end else begin
         cur_byte = hex_char(nib);
      end

      // refill the output register as it drains
      load  = ~out_valid_ff | rsp_pop;
      step  = ~q_empty & load;
      q_pop = step & last;

      pos_in = pos_ff;
      if (step) begin
         pos_in = last ? '0 : pos_ff + 4'd1;
      end

      out_valid_in = step | (out_valid_ff & ~rsp_pop);
      out_in       = out_ff;
      if (step) begin
         out_in.out_byte    = cur_byte;
         out_in.run_last    = last;
         out_in.string_done = last & head_job.eos;
      end

      rsp_empty = ~out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

### sv/utf8_to_latin1_escaping_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                          Beat
// --------  -----------------------------  --------------------------------
// request   req_push, req_full, req_data   one UTF-8 byte + end flag
// response  rsp_pop, rsp_empty, rsp_data   one Latin-1 byte + run/done flags
//
// The decoder takes one byte per cycle while the 4-entry job queue has room.
// The expander emits one output byte per cycle while the output register is
// free or being popped; an item yields 0 to 9 bytes (an escape takes 6 or 8).
// Each result byte is registered in the output register that drives rsp_data.
// Synchronous reset empties the queue and the output register and closes
// any open sequence; a stalled pop backs up through the queue to req_full.

module utf8_to_latin1_escaping_encoder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire u2l_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output u2l_pkg::rsp_type      rsp_data
);
   import u2l_pkg::*;

   logic         job_valid;
   job_type      job;
   job_type      head_job;
   q_status_type q_stat;
   logic         q_pop;

   assign req_full = q_stat.full;

   u2l_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .q_full    (q_stat.full),
      .job_valid (job_valid),
      .job       (job)
   );

   u2l_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_stat)
   );

   u2l_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_empty   (q_stat.empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.string_done) |-> rsp_data.run_last)
      else $error("string_done without run_last");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not idle after reset");

   a_raw_bound: assert property (@(posedge clock) disable iff (reset)
      (job_valid && job.esc != ESC_NONE) |-> (job.raw_count < 3'd4))
      else $error("escape job carries too many raw bytes");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (job_valid && q_stat.empty) |=> !q_stat.empty)
      else $error("job pushed into empty queue was lost");

endmodule

`default_nettype wire

### tb/tb_utf8_to_latin1_escaping_encoder.sv
`timescale 1ns / 1ps

module tb_utf8_to_latin1_escaping_encoder;
   import u2l_pkg::*;

   localparam int RANDOM_ITEMS = 75;
   localparam int HOLD_CYCLES  = 80;
   localparam int STUCK_LIMIT  = 1000;
   localparam int SETTLE       = 16;

   // Golden decoder plus the store of output beats still owed by the block.
   class u2l_scoreboard;
      logic [7:0]  lead;
      logic [7:0]  conts [3];
      logic [1:0]  need;
      logic [1:0]  seen;
      logic [20:0] acc;
      logic [7:0]  run [$];
      rsp_type     owed [$];
      int          fails, items, results, escapes, flushes, names;

      function new();
         foreach (conts[i]) conts[i] = 8'h00;
         close_seq();
      endfunction

      function void close_seq();
         lead = 8'h00;
         need = 2'd0;
         seen = 2'd0;
         acc  = 21'd0;
      endfunction

      function void flush_raw();
         run.push_back(lead);
         for (int i = 0; i < seen; i++) run.push_back(conts[i]);
         flushes++;
         close_seq();
      endfunction

      function void emit_point(logic [20:0] c);
         int         nd;
         logic [3:0] nib;
         if (c == 21'(MARK_BYTE) || c > 21'h0000FF) begin
            nd = (c <= 21'h00FFFF) ? 4 : 6;
            escapes++;
            run.push_back(MARK_BYTE);
            run.push_back(nd == 4 ? ESC_SHORT_TAG : ESC_LONG_TAG);
            for (int k = nd - 1; k >= 0; k--) begin
               nib = 4'((c >> (4 * k)) & 21'hF);
               run.push_back(nib < 4'd10 ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10);
            end
         end else begin
            run.push_back(c[7:0]);
         end
      endfunction

      function void start_fresh(logic [7:0] b, logic eos);
         if (b < 8'h80) begin
            emit_point(21'(b));
            return;
         end
         if (b[7:5] == 3'b110) begin
            need = 2'd1;
            acc  = 21'(b[4:0]);
         end else if (b[7:4] == 4'b1110) begin
            need = 2'd2;
            acc  = 21'(b[3:0]);
         end else if (b[7:3] == 5'b11110) begin
            need = 2'd3;
            acc  = 21'(b[2:0]);
         end else begin
            run.push_back(b);
            return;
         end
         lead = b;
         seen = 2'd0;
         if (eos) flush_raw();
      endfunction

      function void note_beat(req_type r);
         logic [7:0]  b;
         logic        eos;
         bit          took;
         logic [20:0] lo;
         logic [20:0] c;
         rsp_type     e;
         b    = r.in_byte;
         eos  = r.end_of_string;
         took = 0;
         run.delete();
         items++;
         if (eos) names++;
         if (need != 2'd0) begin
            if (b[7:6] == 2'b10) begin
               acc = {acc[14:0], b[5:0]};
               conts[seen] = b;
               seen++;
               if (seen >= need) begin
                  lo = (need == 2'd1) ? 21'h80 : (need == 2'd2) ? 21'h800 : 21'h10000;
                  c  = acc;
                  if (c < lo || c > 21'h10FFFF || (c >= 21'hD800 && c <= 21'hDFFF)) begin
                     flush_raw();
                  end else begin
                     close_seq();
                     emit_point(c);
                  end
               end else if (eos) begin
                  flush_raw();
               end
               took = 1;
            end else begin
               flush_raw();
            end
         end
         if (!took) start_fresh(b, eos);
         foreach (run[i]) begin
            e.out_byte    = run[i];
            e.run_last    = (i == run.size() - 1);
            e.string_done = e.run_last & eos;
            owed.push_back(e);
         end
      endfunction

      function void check_beat(rsp_type got);
         rsp_type e;
         if (owed.size() == 0) begin
            fails++;
            $display("%0t: output beat with nothing owed: expected none, got %h", $time, got);
            return;
         end
         e = owed.pop_front();
         results++;
         if (got.out_byte !== e.out_byte) begin
            fails++;
            $display("%0t: out_byte expected %h, got %h", $time, e.out_byte, got.out_byte);
         end
         if (got.run_last !== e.run_last) begin
            fails++;
            $display("%0t: run_last expected %b, got %b", $time, e.run_last, got.run_last);
         end
         if (got.string_done !== e.string_done) begin
            fails++;
            $display("%0t: string_done expected %b, got %b", $time, e.string_done,
                     got.string_done);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   u2l_scoreboard sb;
   bit            steady   = 0;
   bit            hold_rsp = 0;
   int            stuck_cycles = 0;

   utf8_to_latin1_escaping_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // first byte of the sequence sits in the highest used lane
   function automatic logic [31:0] utf8_form(logic [20:0] c, int len);
      case (len)
         1: return {24'd0, 1'b0, c[6:0]};
         2: return {16'd0, 3'b110, c[10:6], 2'b10, c[5:0]};
         3: return {8'd0, 4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0]};
         default: return {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6], 2'b10, c[5:0]};
      endcase
   endfunction

   task automatic push_beat(input logic [7:0] b, input logic eos);
      int unsigned g;
      g = idle_len();
      if (g != 0) begin
         req_push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{in_byte: b, end_of_string: eos};
      do @(posedge clock); while (req_full);
   endtask

   // eos_mask bit i flags the i-th byte sent
   task automatic push_seq(input logic [31:0] bytes, input int len, input logic [3:0] eos_mask);
      for (int i = 0; i < len; i++) push_beat(bytes[8 * (len - 1 - i) +: 8], eos_mask[i]);
   endtask

   task automatic drain();
      do @(negedge clock); while (sb.owed.size() != 0);
      @(posedge clock);
   endtask

   task automatic run_directed();
      push_seq(32'h01, 1, 4'b0000);
      push_seq(32'h25, 1, 4'b0000);
      push_seq(32'hFF, 1, 4'b0000);          // bad lead
      push_seq(32'hC3A9, 2, 4'b0010);        // plain Latin-1, closes a name
      push_seq(32'hC1BF, 2, 4'b0000);        // overlong
      push_seq(32'hEDA080, 3, 4'b0000);      // surrogate
      push_seq(32'hF4908080, 4, 4'b0000);    // above U+10FFFF
      push_seq(32'hF09F9880, 4, 4'b0000);    // long escape
      push_seq(32'hF09F9825, 4, 4'b0000);    // missing continuation, then '%'
      push_seq(32'hE282, 2, 4'b0010);        // early end mid-sequence
      push_seq(32'hF0, 1, 4'b0001);          // early end on the lead itself
   endtask

   task automatic run_random();
      int          sent, kind, len, drop;
      bit          held, paused;
      logic [31:0] word;
      logic [3:0]  mask;
      logic [20:0] lo;
      sent   = 0;
      held   = 0;
      paused = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 20 && !held) begin
            hold_rsp = 1;
            held     = 1;
         end
         if (sent >= 40 && !paused) begin
            // stop offering while the block empties out
            req_push <= 1'b0;
            drain();
            paused = 1;
         end
         steady = (sent >= 50 && sent < 70);
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            len  = 1;
            word = ($urandom_range(0, 7) == 0) ? 32'h25 : 32'($urandom_range(1, 127));
         end else if (kind < 35) begin
            len  = 2;
            word = utf8_form(21'($urandom_range(21'h80, 21'h7FF)), 2);
         end else if (kind < 55) begin
            len  = 3;
            word = utf8_form(21'($urandom_range(21'h800, 21'hFFFF)), 3);
         end else if (kind < 70) begin
            len  = 4;
            word = utf8_form(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
         end else if (kind < 78) begin
            // overlong: small value in a longer form
            len  = $urandom_range(2, 4);
            lo   = (len == 2) ? 21'h80 : (len == 3) ? 21'h800 : 21'h10000;
            word = utf8_form(21'($urandom_range(0, lo - 1)), len);
         end else if (kind < 84) begin
            len  = 3;
            word = utf8_form(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
         end else if (kind < 88) begin
            len  = 4;
            word = utf8_form(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
         end else if (kind < 94) begin
            // truncated sequence: drop the tail
            len  = $urandom_range(2, 4);
            word = utf8_form(21'($urandom_range(0, 21'h1FFFFF)), len);
            drop = $urandom_range(1, len - 1);
            word = word >> (8 * drop);
            len  = len - drop;
         end else begin
            len  = $urandom_range(1, 3);
            word = '0;
            for (int i = 0; i < len; i++) word = {word[23:0], 8'($urandom_range(1, 255))};
         end
         mask = '0;
         for (int i = 0; i < len; i++) begin
            mask[i] = (i == len - 1) ? ($urandom_range(0, 5) == 0)
                                     : ($urandom_range(0, 24) == 0);
         end
         push_seq(word, len, mask);
         sent += len;
      end
      steady = 0;
   endtask

   // sample both handshakes on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) sb.note_beat(req_data);
         if (rsp_pop && !rsp_empty) sb.check_beat(rsp_data);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
      end
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int unsigned g;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 0;
         end
         g = idle_len();
         if (g != 0) begin
            rsp_pop <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_push <= 1'b0;
      drain();
      repeat (SETTLE) @(posedge clock);
      $display("%0d bytes in across %0d closed names, %0d bytes out", sb.items, sb.names,
               sb.results);
      $display("%0d escapes and %0d raw flushes predicted", sb.escapes, sb.flushes);
      if (sb.owed.size() != 0) begin
         $display("%0t: %0d output beats never arrived", $time, sb.owed.size());
      end
      if (sb.fails == 0 && sb.owed.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### filelist.f
sv/u2l_pkg.sv
sv/u2l_front.sv
sv/u2l_queue.sv
sv/u2l_back.sv
sv/utf8_to_latin1_escaping_encoder.sv
tb/tb_utf8_to_latin1_escaping_encoder.sv
